// ===== hdl/ifs_chaos_game_point_generator_assert.svh =====
// Assertion macros for the RTL files.
`ifndef IFS_CHAOS_GAME_POINT_GENERATOR_ASSERT_SVH
`define IFS_CHAOS_GAME_POINT_GENERATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define IFS_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define IFS_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define IFS_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define IFS_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// ===== hdl/ifs_pkg.sv =====
package ifs_pkg;

    localparam int MaxFunctions  = 16;
    localparam int FuncBits      = (MaxFunctions > 1) ? $clog2(MaxFunctions) : 1;
    localparam int CountBits     = $clog2(MaxFunctions + 1);
    localparam int WordsPerFunc  = 16;
    localparam int TableWords    = MaxFunctions * WordsPerFunc;
    localparam int TableAddrBits = $clog2(TableWords);

    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_SEED = 2'd1;
    localparam logic [1:0] OP_STEP = 2'd2;

    localparam logic [3:0] CFG_FUNCTION_COUNT = 4'd0;
    localparam logic [3:0] CFG_BURN_IN_STEPS  = 4'd1;

    localparam logic [4:0] FUNC_COUNT_RESET = 5'd1;
    localparam logic [7:0] BURN_IN_RESET    = 8'd20;

    typedef struct packed {
        logic [1:0]         op;
        logic [3:0]         func_index;
        logic [3:0]         item_select;
        logic signed [31:0] word_value;
        logic [31:0]        pick;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] x_out;
        logic signed [31:0] y_out;
        logic signed [31:0] z_out;
        logic [15:0]        red_out;
        logic [15:0]        green_out;
        logic [15:0]        blue_out;
        logic [31:0]        sample_index;
        logic               saturated;
    } t_out_word;

endpackage

// ===== hdl/ifs_chaos_game_point_generator.sv =====
// Channel  | Direction | Handshake                 | Payload
// command  | in        | i_start high, o_busy low  | i_cmd  (ifs_pkg::t_in_word)
// result   | out       | o_strobe, one cycle       | o_result (ifs_pkg::t_out_word)
// config   | in        | i_cfg_we                  | i_cfg_index, i_cfg_data
//
// A load, seed or ignored word is taken while idle and leaves o_busy low. A step holds
// o_busy while it scans K weights (1..N), then works on the one shift-add/subtract
// unit: per axis reads and multiplies, then a square; per color a square and a root;
// per axis a divide; then it emits. A zero radius skips the divides.
// Reset (synchronous, active low) clears point, color and counters and sets config to its defaults.
// The receiver cannot stall: a result is shown for one cycle with o_strobe.
`include "ifs_chaos_game_point_generator_assert.svh"
module ifs_chaos_game_point_generator (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    output logic                o_busy,
    input  ifs_pkg::t_in_word   i_cmd,
    output logic                o_strobe,
    output ifs_pkg::t_out_word  o_result,
    input  logic                i_cfg_we,
    input  logic [3:0]          i_cfg_index,
    input  logic [7:0]          i_cfg_data
);

    typedef enum logic [11:0] {
        S_IDLE  = 12'b000000000001,
        S_SCAN  = 12'b000000000010,
        S_CRD   = 12'b000000000100,
        S_MUL   = 12'b000000001000,
        S_MACC  = 12'b000000010000,
        S_SQ    = 12'b000000100000,
        S_COL   = 12'b000001000000,
        S_SQRT  = 12'b000010000000,
        S_DIV   = 12'b000100000000,
        S_DIVF  = 12'b001000000000,
        S_DONE  = 12'b010000000000,
        S_WAIT  = 12'b100000000000
    } t_state;

    // Function table memory
    logic [31:0] r_table [ifs_pkg::TableWords];
    logic [ifs_pkg::TableAddrBits-1:0] r_raddr;
    logic [31:0] r_rdata;

    t_state r_state;
    logic [4:0]  r_fcount;
    logic [7:0]  r_burn_steps;
    logic [7:0]  r_burn_cnt;
    logic [31:0] r_emitted;
    logic signed [31:0] r_pt [3];
    logic [15:0] r_col [3];
    logic [31:0] r_pick;
    logic [32+ifs_pkg::CountBits:0] r_wsum;
    logic [ifs_pkg::CountBits-1:0] r_fi;
    logic [ifs_pkg::CountBits-1:0] r_n;
    logic [ifs_pkg::FuncBits-1:0] r_choice;
    logic [1:0]  r_axis;
    logic [1:0]  r_k;
    logic signed [49:0] r_acc;
    logic signed [31:0] r_t [3];
    logic [65:0] r_d;
    logic        r_flag;
    // shared shift/add unit
    logic [6:0]  r_cnt;
    logic [63:0] r_a;
    logic [63:0] r_b;
    logic [65:0] r_r;
    logic [65:0] r_q;
    logic        r_neg;
    logic [15:0] r_fcol;

    logic [ifs_pkg::CountBits-1:0] w_n;
    always_comb begin
        if (r_fcount == 5'd0) begin
            w_n = ifs_pkg::CountBits'(1);
        end else if (32'(r_fcount) > ifs_pkg::MaxFunctions) begin
            w_n = ifs_pkg::CountBits'(ifs_pkg::MaxFunctions);
        end else begin
            w_n = ifs_pkg::CountBits'(r_fcount);
        end
    end

    logic w_accept;
    assign w_accept = i_start && !o_busy;
    assign o_busy = (r_state != S_IDLE);

    logic [ifs_pkg::FuncBits-1:0] w_cidx;
    assign w_cidx = r_fi[ifs_pkg::FuncBits-1:0];

    // Table write and registered read
    always_ff @(posedge i_clk) begin
        if (w_accept && i_cmd.op == ifs_pkg::OP_LOAD
            && 32'(i_cmd.func_index) < ifs_pkg::MaxFunctions) begin
            r_table[ifs_pkg::TableAddrBits'({i_cmd.func_index, i_cmd.item_select})]
                <= i_cmd.word_value;
        end
        r_rdata <= r_table[r_raddr];
    end

    // Read address select
    always_comb begin
        r_raddr = {r_choice, 4'd0};
        unique case (r_state)
            S_SCAN:  r_raddr = {w_cidx, 4'd0};
            S_COL:   r_raddr = {r_choice, 4'(4'd13 + 4'(r_axis))};
            default: r_raddr = {r_choice, 4'(4'd1 + {r_axis, 2'b00} + 4'(r_k))};
        endcase
    end

    logic [31:0] w_mag;
    logic signed [63:0] w_prod;
    logic signed [49:0] w_fl;
    logic signed [49:0] w_sum;
    logic [65:0] w_rem;
    logic [65:0] w_trial;
    logic [65:0] w_sq_m;
    logic [32:0] w_sqv;

    always_comb begin
        w_prod = $signed(r_r[63:0]);
        w_fl = 50'(w_prod >>> 16);
        w_sum = r_acc + w_fl;
        w_mag = r_t[r_axis][31] ? 32'(-r_t[r_axis]) : r_t[r_axis];
        w_rem = {r_r[64:0], r_a[63]};
        w_trial = w_rem - r_d;
        w_sq_m = {r_r[63:0], r_a[63:62]};
        w_sqv = {r_q[30:0], 2'b01};
    end

    logic [65:0] w_sqt;
    assign w_sqt = w_sq_m - 66'(w_sqv);

    always_ff @(posedge i_clk) begin
        o_strobe <= 1'b0;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fcount <= ifs_pkg::FUNC_COUNT_RESET;
            r_burn_steps <= ifs_pkg::BURN_IN_RESET;
            r_burn_cnt <= '0;
            r_emitted <= '0;
            for (int j = 0; j < 3; j++) begin
                r_pt[j] <= '0;
                r_col[j] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == ifs_pkg::CFG_FUNCTION_COUNT) begin
                    r_fcount <= i_cfg_data[4:0];
                end else if (i_cfg_index == ifs_pkg::CFG_BURN_IN_STEPS) begin
                    r_burn_steps <= i_cfg_data;
                end
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (i_cmd.op == ifs_pkg::OP_SEED && i_cmd.item_select <= 4'd5) begin
                            if (i_cmd.item_select < 4'd3) begin
                                r_pt[2'(i_cmd.item_select)] <= i_cmd.word_value;
                            end else begin
                                r_col[2'(i_cmd.item_select - 4'd3)] <=
                                    i_cmd.word_value[15:0];
                            end
                            r_burn_cnt <= '0;
                            r_emitted <= '0;
                        end else if (i_cmd.op == ifs_pkg::OP_STEP) begin
                            r_pick <= i_cmd.pick;
                            r_wsum <= '0;
                            r_fi <= '0;
                            r_n <= w_n;
                            r_flag <= 1'b0;
                            r_d <= '0;
                            r_cnt <= '0;
                            r_state <= S_SCAN;
                        end
                    end
                end
                // Scan weights: one address then one add per function
                S_SCAN: begin
                    r_cnt <= r_cnt + 7'd1;
                    if (r_cnt[0]) begin
                        if (r_wsum + (ifs_pkg::CountBits+33)'(r_rdata) >
                            (ifs_pkg::CountBits+33)'(r_pick)
                            || r_fi == r_n - 1'b1) begin
                            r_choice <= w_cidx;
                            r_axis <= '0;
                            r_k <= '0;
                            r_state <= S_CRD;
                        end else begin
                            r_wsum <= r_wsum + (ifs_pkg::CountBits+33)'(r_rdata);
                            r_fi <= r_fi + 1'b1;
                        end
                    end
                end
                // Read constant then coefficients
                S_CRD: begin
                    r_cnt <= r_cnt + 7'd1;
                    if (!r_cnt[0]) begin
                        // wait for read data
                    end else if (r_k == 2'd0) begin
                        r_acc <= 50'($signed(r_rdata));
                        r_k <= 2'd1;
                    end else begin
                        r_a <= 64'($signed(r_rdata));
                        r_b <= 64'(r_pt[r_k - 2'd1]);
                        r_r <= '0;
                        r_cnt <= '0;
                        r_state <= S_MUL;
                    end
                end
                // Shift-add multiply, 64 bits modulo 2^64
                S_MUL: begin
                    if (r_b[0]) r_r <= 66'(r_r[63:0] + r_a);
                    r_a <= r_a << 1;
                    r_b <= r_b >> 1;
                    r_cnt <= r_cnt + 7'd1;
                    if (r_cnt == 7'd63) r_state <= S_MACC;
                end
                S_MACC: begin
                    r_cnt <= '0;
                    if (r_k != 2'd3) begin
                        r_acc <= w_sum;
                        r_k <= r_k + 2'd1;
                        r_state <= S_CRD;
                    end else begin
                        if (w_sum > 50'sh7FFFFFFF) begin
                            r_t[r_axis] <= 32'h7FFFFFFF;
                            r_flag <= 1'b1;
                        end else if (w_sum < -50'sh80000000) begin
                            r_t[r_axis] <= 32'h80000000;
                            r_flag <= 1'b1;
                        end else begin
                            r_t[r_axis] <= w_sum[31:0];
                        end
                        r_state <= S_SQ;
                    end
                end
                // Square magnitude into D
                S_SQ: begin
                    if (r_cnt == 7'd0) begin
                        r_a <= 64'(w_mag);
                        r_b <= 64'(w_mag);
                        r_r <= '0;
                        r_cnt <= 7'd1;
                    end else begin
                        if (r_b[0]) r_r <= 66'(r_r[63:0] + r_a);
                        r_a <= r_a << 1;
                        r_b <= r_b >> 1;
                        r_cnt <= r_cnt + 7'd1;
                        if (r_cnt == 7'd34) begin
                            r_d <= r_d + r_r;
                            r_cnt <= '0;
                            r_k <= '0;
                            if (r_axis == 2'd2) begin
                                r_axis <= '0;
                                r_state <= S_COL;
                            end else begin
                                r_axis <= r_axis + 2'd1;
                                r_state <= S_CRD;
                            end
                        end
                    end
                end
                // Color: (c^2 + f^2)/2 via the multiplier, then root
                S_COL: begin
                    r_cnt <= r_cnt + 7'd1;
                    if (r_cnt == 7'd1) begin
                        r_fcol <= r_rdata[15:0];
                        r_a <= 64'(r_col[r_axis]);
                        r_b <= 64'(r_col[r_axis]);
                        r_r <= '0;
                    end else if (r_cnt >= 7'd2 && r_cnt < 7'd18) begin
                        if (r_b[0]) r_r <= 66'(r_r[63:0] + r_a);
                        r_a <= r_a << 1;
                        r_b <= r_b >> 1;
                        if (r_cnt == 7'd17) begin
                            r_q <= '0;
                        end
                    end else if (r_cnt == 7'd18) begin
                        r_q <= r_r;
                        r_a <= 64'(r_fcol);
                        r_b <= 64'(r_fcol);
                        r_r <= '0;
                    end else if (r_cnt < 7'd35) begin
                        if (r_b[0]) r_r <= 66'(r_r[63:0] + r_a);
                        r_a <= r_a << 1;
                        r_b <= r_b >> 1;
                    end else begin
                        r_a <= {31'd0, 33'((r_q[63:0] + r_r[63:0]) >> 1)} << 32;
                        r_q <= '0;
                        r_r <= '0;
                        r_cnt <= '0;
                        r_state <= S_SQRT;
                    end
                end
                // Restoring square root, one result bit per cycle
                S_SQRT: begin
                    r_a <= r_a << 2;
                    r_cnt <= r_cnt + 7'd1;
                    if (!w_sqt[65]) begin
                        r_r <= w_sqt;
                        r_q <= {r_q[64:0], 1'b1};
                    end else begin
                        r_r <= w_sq_m;
                        r_q <= {r_q[64:0], 1'b0};
                    end
                    if (r_cnt == 7'd16) begin
                        r_col[r_axis] <= r_q[15:0];
                        r_cnt <= '0;
                        if (r_axis == 2'd2) begin
                            r_axis <= '0;
                            r_state <= (r_d == '0) ? S_DONE : S_DIV;
                        end else begin
                            r_axis <= r_axis + 2'd1;
                            r_state <= S_COL;
                        end
                    end
                end
                // Restoring divide |t|*2^32 / D
                S_DIV: begin
                    if (r_cnt == 7'd0) begin
                        r_a <= {w_mag, 32'd0};
                        r_neg <= r_t[r_axis][31];
                        r_r <= '0;
                        r_q <= '0;
                        r_cnt <= 7'd1;
                    end else begin
                        r_a <= r_a << 1;
                        r_cnt <= r_cnt + 7'd1;
                        if (!w_trial[65]) begin
                            r_r <= w_trial;
                            r_q <= {r_q[64:0], 1'b1};
                        end else begin
                            r_r <= w_rem;
                            r_q <= {r_q[64:0], 1'b0};
                        end
                        if (r_cnt == 7'd64) r_state <= S_DIVF;
                    end
                end
                S_DIVF: begin
                    r_cnt <= '0;
                    if (r_neg) begin
                        if (r_q > 66'h80000000) begin
                            r_pt[r_axis] <= 32'h80000000;
                            r_flag <= 1'b1;
                        end else begin
                            r_pt[r_axis] <= 32'(-r_q[31:0]);
                        end
                    end else if (r_q > 66'h7FFFFFFF) begin
                        r_pt[r_axis] <= 32'h7FFFFFFF;
                        r_flag <= 1'b1;
                    end else begin
                        r_pt[r_axis] <= r_q[31:0];
                    end
                    if (r_axis == 2'd2) begin
                        r_state <= S_WAIT;
                    end else begin
                        r_axis <= r_axis + 2'd1;
                        r_state <= S_DIV;
                    end
                end
                // Zero denominator
                S_DONE: begin
                    for (int j = 0; j < 3; j++) r_pt[j] <= '0;
                    r_flag <= 1'b1;
                    r_state <= S_WAIT;
                end
                // Emit or count burn-in
                S_WAIT: begin
                    if (r_burn_cnt < r_burn_steps) begin
                        r_burn_cnt <= r_burn_cnt + 8'd1;
                    end else begin
                        o_strobe <= 1'b1;
                        r_emitted <= r_emitted + 32'd1;
                    end
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Result word
    always_ff @(posedge i_clk) begin
        if (r_state == S_WAIT) begin
            o_result.x_out <= r_pt[0];
            o_result.y_out <= r_pt[1];
            o_result.z_out <= r_pt[2];
            o_result.red_out <= r_col[0];
            o_result.green_out <= r_col[1];
            o_result.blue_out <= r_col[2];
            o_result.sample_index <= r_emitted;
            o_result.saturated <= r_flag;
        end
    end

    `IFS_ASSERT_IMPL(a_strobe_idle, i_clk, i_rst_n, o_strobe |-> r_state == S_IDLE,
        "result shown while busy")
    `IFS_ASSERT_IMPL(a_strobe_one, i_clk, i_rst_n, o_strobe |=> !o_strobe,
        "result strobe held")
    `IFS_ASSERT_IMPL(a_burn_cap, i_clk, i_rst_n, o_strobe |-> r_burn_cnt >= r_burn_steps,
        "result during burn-in")
endmodule

// ===== dv/ifs_chaos_game_point_generator_checker.sv =====
`timescale 1ns / 100ps

// Watch the command, config and result channels, predict every point and compare.
module ifs_chaos_game_point_generator_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_busy,
    input  ifs_pkg::t_in_word  i_cmd,
    input  logic               i_strobe,
    input  ifs_pkg::t_out_word i_result,
    input  logic               i_cfg_we,
    input  logic [3:0]         i_cfg_index,
    input  logic [7:0]         i_cfg_data,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_point_count,
    output int                 o_step_count
);

    // Shadow state of the generator
    logic [31:0] func_mem [ifs_pkg::TableWords];
    logic [31:0] pos [3];
    logic [15:0] hue [3];
    logic [7:0]  warm_count;
    logic [31:0] emit_count;
    logic [4:0]  func_count;
    logic [7:0]  warm_steps;

    ifs_pkg::t_out_word point_q [$];

    // Floor of the square root, bit by bit
    function automatic logic [31:0] root_floor(input longint unsigned m);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > m) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (m >= res + bitv) begin
                m   = m - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res[31:0];
    endfunction

    // Divide one axis by the squared radius, clamp to Q16.16
    function automatic logic [31:0] invert_coord(input longint t, input longint unsigned d,
                                                 inout logic sat);
        longint unsigned mag;
        longint unsigned q;
        mag = (t < 0) ? longint'(-t) : longint'(t);
        q   = (mag << 32) / d;
        if (t < 0) begin
            if (q > 64'h8000_0000) begin
                sat = 1'b1;
                return 32'h8000_0000;
            end
            return 32'(0 - q);
        end
        if (q > 64'h7FFF_FFFF) begin
            sat = 1'b1;
            return 32'h7FFF_FFFF;
        end
        return q[31:0];
    endfunction

    // Advance one chaos-game step; returns 1 when the point is emitted
    function automatic logic step_point(input logic [31:0] pick,
                                        output ifs_pkg::t_out_word pt);
        int              n;
        int              choice;
        int              base;
        logic            found;
        logic            sat;
        longint unsigned wsum;
        longint unsigned d;
        longint unsigned mag;
        longint          acc;
        longint          t [3];
        logic [31:0]     nx [3];
        longint unsigned cc;
        longint unsigned ff;
        n = func_count;
        if (n < 1) n = 1;
        if (n > ifs_pkg::MaxFunctions) n = ifs_pkg::MaxFunctions;
        choice = n - 1;
        found  = 1'b0;
        wsum   = 0;
        sat    = 1'b0;
        d      = 0;
        for (int i = 0; i < n; i++) begin
            if (!found) begin
                wsum += func_mem[i * ifs_pkg::WordsPerFunc];
                if (wsum > pick) begin
                    choice = i;
                    found  = 1'b1;
                end
            end
        end
        base = choice * ifs_pkg::WordsPerFunc;
        // Affine map per axis, each product floored to Q16.16
        for (int a = 0; a < 3; a++) begin
            acc = longint'($signed(func_mem[base + 1 + 4 * a]));
            for (int k = 0; k < 3; k++)
                acc += (longint'($signed(func_mem[base + 2 + 4 * a + k])) *
                        longint'($signed(pos[k]))) >>> 16;
            if (acc > 64'sh7FFF_FFFF) begin
                sat = 1'b1;
                acc = 64'sh7FFF_FFFF;
            end else if (acc < -64'sh8000_0000) begin
                sat = 1'b1;
                acc = -64'sh8000_0000;
            end
            t[a] = acc;
            mag  = (acc < 0) ? longint'(-acc) : longint'(acc);
            d   += mag * mag;
        end
        // Blend color as root mean square
        for (int c = 0; c < 3; c++) begin
            cc     = hue[c];
            ff     = func_mem[base + 13 + c][15:0];
            hue[c] = root_floor((cc * cc + ff * ff) >> 1);
        end
        // Invert through the unit sphere
        for (int a = 0; a < 3; a++) begin
            if (d == 0) begin
                sat   = 1'b1;
                nx[a] = '0;
            end else begin
                nx[a] = invert_coord(t[a], d, sat);
            end
        end
        for (int a = 0; a < 3; a++) pos[a] = nx[a];
        pt = '0;
        if (warm_count < warm_steps) begin
            warm_count++;
            return 1'b0;
        end
        pt.x_out        = pos[0];
        pt.y_out        = pos[1];
        pt.z_out        = pos[2];
        pt.red_out      = hue[0];
        pt.green_out    = hue[1];
        pt.blue_out     = hue[2];
        pt.sample_index = emit_count;
        pt.saturated    = sat;
        emit_count++;
        return 1'b1;
    endfunction

    // Track accepted words, check strobed points
    always @(posedge i_clk) begin
        ifs_pkg::t_out_word exp_pt;
        ifs_pkg::t_out_word new_pt;
        if (!i_rst_n) begin
            foreach (func_mem[i]) func_mem[i] = '0;
            foreach (pos[i]) pos[i] = '0;
            foreach (hue[i]) hue[i] = '0;
            warm_count    = '0;
            emit_count    = '0;
            func_count    = ifs_pkg::FUNC_COUNT_RESET;
            warm_steps    = ifs_pkg::BURN_IN_RESET;
            point_q.delete();
            o_fail_count  <= 0;
            o_point_count <= 0;
            o_step_count  <= 0;
        end else begin
            // Compare a strobed point with the oldest expectation
            if (i_strobe) begin
                if (point_q.size() == 0) begin
                    $error("unexpected point word");
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_pt = point_q.pop_front();
                    o_point_count <= o_point_count + 1;
                    if (i_result != exp_pt) o_fail_count <= o_fail_count + 1;
                    if (i_result.x_out != exp_pt.x_out)
                        $error("x_out exp %h got %h", exp_pt.x_out, i_result.x_out);
                    if (i_result.y_out != exp_pt.y_out)
                        $error("y_out exp %h got %h", exp_pt.y_out, i_result.y_out);
                    if (i_result.z_out != exp_pt.z_out)
                        $error("z_out exp %h got %h", exp_pt.z_out, i_result.z_out);
                    if (i_result.red_out != exp_pt.red_out)
                        $error("red_out exp %h got %h", exp_pt.red_out, i_result.red_out);
                    if (i_result.green_out != exp_pt.green_out)
                        $error("green_out exp %h got %h", exp_pt.green_out,
                               i_result.green_out);
                    if (i_result.blue_out != exp_pt.blue_out)
                        $error("blue_out exp %h got %h", exp_pt.blue_out, i_result.blue_out);
                    if (i_result.sample_index != exp_pt.sample_index)
                        $error("sample_index exp %0d got %0d", exp_pt.sample_index,
                               i_result.sample_index);
                    if (i_result.saturated != exp_pt.saturated)
                        $error("saturated exp %b got %b", exp_pt.saturated,
                               i_result.saturated);
                end
            end
            // Apply register writes
            if (i_cfg_we) begin
                if (i_cfg_index == ifs_pkg::CFG_FUNCTION_COUNT)
                    func_count = i_cfg_data[4:0];
                else if (i_cfg_index == ifs_pkg::CFG_BURN_IN_STEPS)
                    warm_steps = i_cfg_data;
            end
            // Apply an accepted command word
            if (i_start && !i_busy) begin
                case (i_cmd.op)
                    ifs_pkg::OP_LOAD: begin
                        func_mem[{i_cmd.func_index, i_cmd.item_select}] = i_cmd.word_value;
                    end
                    ifs_pkg::OP_SEED: begin
                        if (i_cmd.item_select <= 4'd5) begin
                            if (i_cmd.item_select < 4'd3)
                                pos[i_cmd.item_select] = i_cmd.word_value;
                            else
                                hue[i_cmd.item_select - 4'd3] = i_cmd.word_value[15:0];
                            warm_count = '0;
                            emit_count = '0;
                        end
                    end
                    ifs_pkg::OP_STEP: begin
                        o_step_count <= o_step_count + 1;
                        if (step_point(i_cmd.pick, new_pt)) point_q.push_back(new_pt);
                    end
                    default: ;
                endcase
            end
        end
        o_pending <= point_q.size();
    end

endmodule

// ===== dv/tb_ifs_chaos_game_point_generator.sv =====
`timescale 1ns / 100ps

module tb_ifs_chaos_game_point_generator;

    localparam int CycleLimit = 10_000_000;
    localparam int DrainWait  = 600;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_start;
    logic               o_busy;
    ifs_pkg::t_in_word  i_cmd;
    logic               o_strobe;
    ifs_pkg::t_out_word o_result;
    logic               i_cfg_we;
    logic [3:0]         i_cfg_index;
    logic [7:0]         i_cfg_data;

    int fail_count;
    int pending;
    int point_count;
    int step_count;
    int cycles;
    int word_count;
    int cfg_count;
    int live_funcs;
    logic [31:0] weights [ifs_pkg::MaxFunctions];

    typedef struct {
        logic [4:0] fc;
        logic [7:0] burn;
        int         items;
        logic       seeds;
    } t_phase;

    ifs_chaos_game_point_generator dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .o_busy     (o_busy),
        .i_cmd      (i_cmd),
        .o_strobe   (o_strobe),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    ifs_chaos_game_point_generator_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .i_busy       (o_busy),
        .i_cmd        (i_cmd),
        .i_strobe     (o_strobe),
        .i_result     (o_result),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_point_count(point_count),
        .o_step_count (step_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CycleLimit) begin
            $display("[ifs_chaos_game_point_generator] ERROR");
            $finish;
        end
    end

    function automatic ifs_pkg::t_in_word mk_word(logic [1:0] op, logic [3:0] fi,
                                                  logic [3:0] sel, logic [31:0] val,
                                                  logic [31:0] pick);
        ifs_pkg::t_in_word w;
        w.op          = op;
        w.func_index  = fi;
        w.item_select = sel;
        w.word_value  = val;
        w.pick        = pick;
        return w;
    endfunction

    // Mostly coefficients within +-2.0, sometimes any word
    function automatic logic [31:0] coef_value();
        if ($urandom_range(0, 9) < 7) return $urandom_range(0, 32'h40000) - 32'h20000;
        return $urandom;
    endfunction

    // Pick below the total weight of the functions in use, now and then anything
    function automatic logic [31:0] pick_value();
        longint unsigned total;
        total = 0;
        for (int i = 0; i < live_funcs; i++) total += weights[i];
        if ($urandom_range(0, 99) < 10 || total == 0) return $urandom;
        if (total > 64'hFFFF_FFFF) return $urandom;
        return $urandom_range(0, 32'(total - 1));
    endfunction

    function automatic ifs_pkg::t_in_word rand_word(logic seeds);
        int          r;
        logic [3:0]  sel;
        logic [31:0] val;
        r = $urandom_range(0, 99);
        if (r < 50 || (!seeds && r >= 70 && r < 92))
            return mk_word(ifs_pkg::OP_STEP, 4'($urandom), 4'($urandom), $urandom,
                           pick_value());
        if (r < 70) begin
            sel = 4'($urandom);
            if (sel == 4'd0)
                val = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 32'h40000) : $urandom;
            else if (sel >= 4'd13) val = $urandom;
            else val = coef_value();
            return mk_word(ifs_pkg::OP_LOAD, 4'($urandom), sel, val, $urandom);
        end
        if (r < 85)
            return mk_word(ifs_pkg::OP_SEED, 4'($urandom), 4'($urandom_range(0, 5)),
                           coef_value(), $urandom);
        if (r < 92)
            return mk_word(ifs_pkg::OP_SEED, 4'($urandom), 4'($urandom_range(6, 15)),
                           $urandom, $urandom);
        return mk_word(2'd3, 4'($urandom), 4'($urandom), $urandom, $urandom);
    endfunction

    // Send words back to back or with random gaps; start stays high between words unless a gap follows
    task automatic send_list(ref ifs_pkg::t_in_word q [$], input logic gaps);
        int gap;
        foreach (q[k]) begin
            gap = 0;
            if (gaps && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 10);
            i_cmd   <= q[k];
            i_start <= 1'b1;
            do @(posedge i_clk); while (o_busy);
            word_count++;
            if (q[k].op == ifs_pkg::OP_LOAD && q[k].item_select == 4'd0)
                weights[q[k].func_index] = q[k].word_value;
            if (gap > 0 || k == q.size() - 1) begin
                i_start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic write_reg(logic [3:0] idx, logic [7:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
        cfg_count++;
    endtask

    // Hold until every point is out and the block has settled
    task automatic wait_idle();
        do @(posedge i_clk); while (pending != 0 || o_busy);
        repeat (DrainWait) @(posedge i_clk);
    endtask

    task automatic set_config(logic [4:0] fc, logic [7:0] burn);
        write_reg(ifs_pkg::CFG_FUNCTION_COUNT, {3'($urandom_range(0, 7)), fc});
        write_reg(ifs_pkg::CFG_BURN_IN_STEPS, burn);
        live_funcs = (fc == 0) ? 1 : (fc > ifs_pkg::MaxFunctions) ? ifs_pkg::MaxFunctions : fc;
    endtask

    initial begin
        ifs_pkg::t_in_word q [$];
        t_phase            phases [$];
        i_rst_n     = 1'b0;
        i_start     = 1'b0;
        i_cmd       = '0;
        i_cfg_we    = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        cycles      = 0;
        word_count  = 0;
        cfg_count   = 0;
        live_funcs  = 1;
        foreach (weights[i]) weights[i] = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_config(5'd16, 8'd0);

        // Fill every table word before any step reads it
        for (int f = 0; f < ifs_pkg::MaxFunctions; f++)
            for (int s = 0; s < ifs_pkg::WordsPerFunc; s++)
                q.push_back(mk_word(ifs_pkg::OP_LOAD, 4'(f), 4'(s),
                    (s == 0) ? $urandom_range(0, 32'h40000) :
                    (s >= 13) ? $urandom : coef_value(), $urandom));
        send_list(q, 1'b1);
        q.delete();

        // Directed: zero radius, inversion clamps both ways, extreme seeds, fallback,
        // ignored op and ignored seed selects
        q.push_back(mk_word(ifs_pkg::OP_LOAD, 0, 0, 32'h7FFF_FFFF, 0));
        q.push_back(mk_word(ifs_pkg::OP_LOAD, 0, 1, 0, 0));
        q.push_back(mk_word(ifs_pkg::OP_LOAD, 0, 5, 0, 0));
        q.push_back(mk_word(ifs_pkg::OP_LOAD, 0, 9, 0, 0));
        q.push_back(mk_word(ifs_pkg::OP_SEED, 0, 0, 0, 0));
        q.push_back(mk_word(ifs_pkg::OP_SEED, 0, 1, 0, 0));
        q.push_back(mk_word(ifs_pkg::OP_SEED, 0, 2, 0, 0));
        q.push_back(mk_word(ifs_pkg::OP_STEP, 0, 0, 0, 32'd0));
        q.push_back(mk_word(ifs_pkg::OP_LOAD, 0, 1, 32'd1, 0));
        q.push_back(mk_word(ifs_pkg::OP_STEP, 0, 0, 0, 32'd0));
        q.push_back(mk_word(ifs_pkg::OP_SEED, 0, 0, 0, 0));
        q.push_back(mk_word(ifs_pkg::OP_LOAD, 0, 1, 32'hFFFF_FFFF, 0));
        q.push_back(mk_word(ifs_pkg::OP_STEP, 0, 0, 0, 32'd0));
        q.push_back(mk_word(ifs_pkg::OP_SEED, 4'hF, 0, 32'h8000_0000, 32'hFFFF_FFFF));
        q.push_back(mk_word(ifs_pkg::OP_SEED, 0, 1, 32'h7FFF_FFFF, 0));
        q.push_back(mk_word(ifs_pkg::OP_SEED, 0, 2, 32'h8000_0000, 0));
        q.push_back(mk_word(ifs_pkg::OP_SEED, 0, 3, 32'h0000_FFFF, 0));
        q.push_back(mk_word(ifs_pkg::OP_SEED, 0, 4, 32'hFFFF_0000, 0));
        q.push_back(mk_word(ifs_pkg::OP_SEED, 0, 5, 32'hFFFF_FFFF, 0));
        q.push_back(mk_word(ifs_pkg::OP_STEP, 4'hF, 4'hF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        q.push_back(mk_word(2'd3, 4'hF, 4'hF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        q.push_back(mk_word(ifs_pkg::OP_SEED, 0, 6, 32'h1234_5678, 0));
        q.push_back(mk_word(ifs_pkg::OP_SEED, 0, 15, 32'hFFFF_FFFF, 0));
        q.push_back(mk_word(ifs_pkg::OP_STEP, 0, 0, 0, 32'd0));
        send_list(q, 1'b0);
        q.delete();

        // Random phases over several register settings, extremes among them
        phases.push_back('{5'd0,  8'd3,   150, 1'b1});
        phases.push_back('{5'd31, 8'd1,   150, 1'b1});
        phases.push_back('{5'd1,  8'd0,   150, 1'b1});
        phases.push_back('{5'd7,  8'd255, 300, 1'b0});
        phases.push_back('{5'd5,  8'd2,   150, 1'b1});
        phases.push_back('{5'd16, 8'd1,   150, 1'b1});
        phases.push_back('{5'd12, 8'd0,   150, 1'b1});
        phases.push_back('{5'd3,  8'd4,   150, 1'b1});
        foreach (phases[p]) begin
            wait_idle();
            set_config(phases[p].fc, phases[p].burn);
            if (p == 2) write_reg(4'hF, 8'($urandom));
            for (int k = 0; k < phases[p].items; k++) q.push_back(rand_word(phases[p].seeds));
            send_list(q, p != phases.size() - 1);
            q.delete();
        end

        wait_idle();
        $display("Sent %0d command words (%0d steps) across %0d register writes;",
                 word_count, step_count, cfg_count);
        $display("checked %0d emitted points against the predicted stream.", point_count);
        if (fail_count == 0) begin
            $display("[ifs_chaos_game_point_generator] OK");
        end else begin
            $display("[ifs_chaos_game_point_generator] ERROR");
        end
        $finish;
    end

endmodule
